// File: sv/waypoint_pose_interpolator_assert.svh
// assertion macros for the waypoint pose interpolator
// used by modules that check their own control behavior
`ifndef WAYPOINT_POSE_INTERPOLATOR_ASSERT_SVH
`define WAYPOINT_POSE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, checked on clk_i while out of reset
`define WPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wpi assertion failed");

// next-cycle implication
`define WPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wpi assertion failed");

`endif

// File: sv/wpi_pkg.sv
// shared types and constants of the waypoint pose interpolator
// no dependencies
package wpi_pkg;

  localparam int unsigned N_SLOTS   = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned HDG_W     = 16;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned DCNT_W    = 6;
  localparam int unsigned MUL_W     = 51;

  localparam logic [DCNT_W-1:0] DIV_MOD_STEPS  = DCNT_W'(TIME_W + 1);
  localparam logic [DCNT_W-1:0] DIV_FRAC_STEPS = DCNT_W'(FRAC_W + 1);

  localparam logic signed [POS_W-1:0] HEIGHT_RESET = 32'sd66191;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]        t;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [HDG_W-1:0]  h;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_RD_LAST,
    CMD_CAP_LAST,
    CMD_MOD_START,
    CMD_DIV_STEP,
    CMD_MOD_FIN,
    CMD_OUT_FIRST,
    CMD_OUT_LAST,
    CMD_SRCH_START,
    CMD_SRCH_NEXT,
    CMD_SRCH_HIT,
    CMD_MUL_X,
    CMD_MUL_Y,
    CMD_MUL_H,
    CMD_HFIN,
    CMD_PUSH
  } cmd_e;

  typedef struct packed {
    logic in_load;
    logic in_query;
    logic need_wrap;
    logic le_first;
    logic ge_last;
    logic srch_stop;
    logic div_done;
  } dp_stat_t;

endpackage

// File: sv/wpi_dp.sv
// datapath: waypoint table, config registers, shared divider and multiplier
// depends on wpi_pkg
module wpi_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wpi_pkg::cmd_e                    cmd_i,
  output wpi_pkg::dp_stat_t                stat_o,
  input  logic                             cfg_we_i,
  input  logic [wpi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wpi_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             mode_i,
  input  logic                             paused_i,
  input  logic [wpi_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [wpi_pkg::TIME_W-1:0]       entry_time_i,
  input  logic signed [wpi_pkg::POS_W-1:0] entry_x_i,
  input  logic signed [wpi_pkg::POS_W-1:0] entry_y_i,
  input  logic signed [wpi_pkg::HDG_W-1:0] entry_heading_i,
  input  logic [wpi_pkg::TIME_W-1:0]       query_time_i,
  output logic signed [wpi_pkg::POS_W-1:0] pose_x_o,
  output logic signed [wpi_pkg::POS_W-1:0] pose_y_o,
  output logic signed [wpi_pkg::POS_W-1:0] pose_z_o,
  output logic signed [wpi_pkg::HDG_W-1:0] pose_heading_o
);
  import wpi_pkg::*;

  entry_t mem [N_SLOTS];
  entry_t rdata_q, e0_q, el_q, prev_q, cur_q;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr, idx_q, last_idx;
  logic [CNT_W-1:0]    n_cl;

  logic                loop_q;
  logic signed [POS_W-1:0] height_q;
  logic [CNT_W-1:0]    count_q;

  logic [TIME_W-1:0]   t_q, den_q, dvd_q;
  logic [TIME_W:0]     r_q, r_sh, r_nx;
  logic [FRAC_W:0]     quo_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic                first_q, ge;

  logic signed [FRAC_W+1:0]  mul_a;
  logic signed [POS_W:0]     mul_b, dx, dy;
  logic signed [HDG_W+1:0]   dh, dh_adj;
  logic signed [MUL_W-1:0]   mul_p, prod_q;

  logic signed [POS_W-1:0] res_x_q, res_y_q;
  logic signed [HDG_W-1:0] res_h_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b0;
      height_q <= HEIGHT_RESET;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOOP:   loop_q   <= cfg_data_i[0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_cl     = (count_q > CNT_W'(N_SLOTS)) ? CNT_W'(N_SLOTS) : count_q;
  assign last_idx = IDX_W'(n_cl - CNT_W'(1));

  // waypoint table
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      mem[entry_index_i] <= '{t: entry_time_i, x: entry_x_i, y: entry_y_i,
                              h: entry_heading_i};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (cmd_i)
      CMD_START:      rd_addr = '0;
      CMD_RD_LAST:    rd_addr = last_idx;
      CMD_SRCH_START: rd_addr = IDX_W'(1);
      CMD_SRCH_NEXT:  rd_addr = idx_q + IDX_W'(1);
      default:        rd_en = 1'b0;
    endcase
  end

  // divider step
  assign r_sh = first_q ? r_q : {r_q[TIME_W-1:0], dvd_q[TIME_W-1]};
  assign ge   = r_sh >= {1'b0, den_q};
  assign r_nx = ge ? (r_sh - {1'b0, den_q}) : r_sh;

  // multiplier operands
  assign dx = {cur_q.x[POS_W-1], cur_q.x} - {prev_q.x[POS_W-1], prev_q.x};
  assign dy = {cur_q.y[POS_W-1], cur_q.y} - {prev_q.y[POS_W-1], prev_q.y};
  assign dh = {{2{cur_q.h[HDG_W-1]}}, cur_q.h} - {{2{prev_q.h[HDG_W-1]}}, prev_q.h};

  always_comb begin
    dh_adj = dh;
    if (dh > (HDG_W+2)'(32768)) begin
      dh_adj = dh - (HDG_W+2)'(65536);
    end else if (dh < -(HDG_W+2)'(32768)) begin
      dh_adj = dh + (HDG_W+2)'(65536);
    end
  end

  always_comb begin
    case (cmd_i)
      CMD_MUL_X: mul_b = dx;
      CMD_MUL_Y: mul_b = dy;
      default:   mul_b = {{(POS_W-HDG_W-1){dh_adj[HDG_W+1]}}, dh_adj};
    endcase
  end

  assign mul_a = {1'b0, quo_q};
  assign mul_p = MUL_W'(mul_a * mul_b);

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_START:    t_q <= query_time_i;
      CMD_RD_LAST:  e0_q <= rdata_q;
      CMD_CAP_LAST: el_q <= rdata_q;
      CMD_MOD_START: begin
        r_q   <= '0;
        dvd_q <= t_q - e0_q.t;
        den_q <= el_q.t - e0_q.t;
      end
      CMD_DIV_STEP: begin
        r_q   <= r_nx;
        dvd_q <= first_q ? dvd_q : {dvd_q[TIME_W-2:0], 1'b0};
        quo_q <= {quo_q[FRAC_W-1:0], ge};
      end
      CMD_MOD_FIN:  t_q <= e0_q.t + r_q[TIME_W-1:0];
      CMD_OUT_FIRST: begin
        res_x_q <= e0_q.x;
        res_y_q <= e0_q.y;
        res_h_q <= e0_q.h;
      end
      CMD_OUT_LAST: begin
        res_x_q <= el_q.x;
        res_y_q <= el_q.y;
        res_h_q <= el_q.h;
      end
      CMD_SRCH_START: begin
        prev_q <= e0_q;
        idx_q  <= IDX_W'(1);
      end
      CMD_SRCH_NEXT: begin
        prev_q <= rdata_q;
        idx_q  <= idx_q + IDX_W'(1);
      end
      CMD_SRCH_HIT: begin
        cur_q <= rdata_q;
        r_q   <= {1'b0, t_q - prev_q.t};
        dvd_q <= '0;
        den_q <= rdata_q.t - prev_q.t;
      end
      CMD_MUL_X: prod_q <= mul_p;
      CMD_MUL_Y: begin
        res_x_q <= prev_q.x + prod_q[FRAC_W+POS_W-1:FRAC_W];
        prod_q  <= mul_p;
      end
      CMD_MUL_H: begin
        res_y_q <= prev_q.y + prod_q[FRAC_W+POS_W-1:FRAC_W];
        prod_q  <= mul_p;
      end
      CMD_HFIN: res_h_q <= prev_q.h + prod_q[FRAC_W+HDG_W-1:FRAC_W];
      CMD_PUSH: begin
        pose_x_o       <= res_x_q;
        pose_y_o       <= res_y_q;
        pose_z_o       <= height_q;
        pose_heading_o <= res_h_q;
      end
      default: ;
    endcase
  end

  // divider sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q  <= '0;
      first_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_MOD_START: begin
          dcnt_q  <= DIV_MOD_STEPS;
          first_q <= 1'b1;
        end
        CMD_SRCH_HIT: begin
          dcnt_q  <= DIV_FRAC_STEPS;
          first_q <= 1'b1;
        end
        CMD_DIV_STEP: begin
          dcnt_q  <= dcnt_q - DCNT_W'(1);
          first_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.in_load   = !mode_i;
  assign stat_o.in_query  = mode_i && !paused_i && (n_cl >= CNT_W'(2));
  assign stat_o.need_wrap = loop_q && (el_q.t > e0_q.t) && (t_q > el_q.t);
  assign stat_o.le_first  = t_q <= e0_q.t;
  assign stat_o.ge_last   = t_q >= el_q.t;
  assign stat_o.srch_stop = (idx_q == last_idx) || (rdata_q.t >= t_q);
  assign stat_o.div_done  = dcnt_q == '0;

endmodule

// File: sv/wpi_ctrl.sv
// controller: sequences table reads, wrap, search, division and interpolation
// depends on wpi_pkg and waypoint_pose_interpolator_assert.svh
`include "waypoint_pose_interpolator_assert.svh"
module wpi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wpi_pkg::dp_stat_t stat_i,
  output wpi_pkg::cmd_e     cmd_o
);
  import wpi_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_RD_LAST  = 13'b0000000000010,
    S_CAP_LAST = 13'b0000000000100,
    S_CHECK    = 13'b0000000001000,
    S_MOD      = 13'b0000000010000,
    S_CLAMP    = 13'b0000000100000,
    S_SRCH     = 13'b0000001000000,
    S_FRAC     = 13'b0000010000000,
    S_MULX     = 13'b0000100000000,
    S_MULY     = 13'b0001000000000,
    S_MULH     = 13'b0010000000000,
    S_HFIN     = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.in_load) begin
          cmd_o = CMD_LOAD;
        end else if (in_valid_i && stat_i.in_query) begin
          cmd_o   = CMD_START;
          state_d = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd_o   = CMD_RD_LAST;
        state_d = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd_o   = CMD_CAP_LAST;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.need_wrap) begin
          cmd_o   = CMD_MOD_START;
          state_d = S_MOD;
        end else begin
          state_d = S_CLAMP;
        end
      end
      S_MOD: begin
        if (stat_i.div_done) begin
          cmd_o   = CMD_MOD_FIN;
          state_d = S_CLAMP;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_CLAMP: begin
        if (stat_i.le_first) begin
          cmd_o   = CMD_OUT_FIRST;
          state_d = S_OUT;
        end else if (stat_i.ge_last) begin
          cmd_o   = CMD_OUT_LAST;
          state_d = S_OUT;
        end else begin
          cmd_o   = CMD_SRCH_START;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat_i.srch_stop) begin
          cmd_o   = CMD_SRCH_HIT;
          state_d = S_FRAC;
        end else begin
          cmd_o = CMD_SRCH_NEXT;
        end
      end
      S_FRAC: begin
        if (stat_i.div_done) begin
          state_d = S_MULX;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      S_MULX: begin
        cmd_o   = CMD_MUL_X;
        state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o   = CMD_MUL_Y;
        state_d = S_MULH;
      end
      S_MULH: begin
        cmd_o   = CMD_MUL_H;
        state_d = S_HFIN;
      end
      S_HFIN: begin
        cmd_o   = CMD_HFIN;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o   = CMD_PUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o == CMD_PUSH) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a push never overwrites a result that has not been transferred
  `WPI_ASSERT_IMP(a_push_free, cmd_o == CMD_PUSH, !out_valid_q || out_ready_i)
  // a finished fraction goes straight to interpolation
  `WPI_ASSERT_NXT(a_frac_to_mul, state_q == S_FRAC && stat_i.div_done, state_q == S_MULX)
  // a new result only comes from the output state
  `WPI_ASSERT_IMP(a_rise_from_out, $rose(out_valid_q), $past(state_q) == S_OUT)

endmodule

// File: sv/waypoint_pose_interpolator.sv
// waypoint pose interpolator top level: wpi_ctrl and wpi_dp, depends on wpi_pkg
// a clamped pose goes through last-entry read, wrap check and clamp to output; a wrapped
// time adds a modulo division, an inner time a table search, fraction division and x, y, h
// interpolation; one item at a time: a load or unanswered query leaves the block idle, a
// query is taken again the cycle after its result is pushed, which waits while the previous
// result is not transferred; reset clears control, presets config; the table is undefined until loaded
module waypoint_pose_interpolator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic                             paused_i,
  input  logic [wpi_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [wpi_pkg::TIME_W-1:0]       entry_time_i,
  input  logic signed [wpi_pkg::POS_W-1:0] entry_x_i,
  input  logic signed [wpi_pkg::POS_W-1:0] entry_y_i,
  input  logic signed [wpi_pkg::HDG_W-1:0] entry_heading_i,
  input  logic [wpi_pkg::TIME_W-1:0]       query_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [wpi_pkg::POS_W-1:0] pose_x_o,
  output logic signed [wpi_pkg::POS_W-1:0] pose_y_o,
  output logic signed [wpi_pkg::POS_W-1:0] pose_z_o,
  output logic signed [wpi_pkg::HDG_W-1:0] pose_heading_o,
  input  logic                             cfg_we_i,
  input  logic [wpi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wpi_pkg::CFG_W-1:0]        cfg_data_i
);
  import wpi_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  wpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wpi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .paused_i        (paused_i),
    .entry_index_i   (entry_index_i),
    .entry_time_i    (entry_time_i),
    .entry_x_i       (entry_x_i),
    .entry_y_i       (entry_y_i),
    .entry_heading_i (entry_heading_i),
    .query_time_i    (query_time_i),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .pose_z_o        (pose_z_o),
    .pose_heading_o  (pose_heading_o)
  );

endmodule

// File: test/tb_waypoint_pose_interpolator.sv
// self-checking testbench for waypoint_pose_interpolator: loads waypoint tables, sends
// pose queries under random handshake gaps, and checks each pose against an in-bench predictor
// depends on wpi_pkg and waypoint_pose_interpolator
module tb_waypoint_pose_interpolator;
  import wpi_pkg::*;

  localparam bit MODE_LOAD  = 1'b0;
  localparam bit MODE_QUERY = 1'b1;
  localparam int SETTLE     = 120;
  localparam int LIMIT      = 1500000;

  typedef struct {
    bit                       mode;
    bit                       paused;
    logic [IDX_W-1:0]         idx;
    logic [TIME_W-1:0]        et;
    logic signed [POS_W-1:0]  ex;
    logic signed [POS_W-1:0]  ey;
    logic signed [HDG_W-1:0]  eh;
    logic [TIME_W-1:0]        qt;
  } item_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [HDG_W-1:0] h;
  } pose_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, mode_i, paused_i;
  logic [IDX_W-1:0] entry_index_i;
  logic [TIME_W-1:0] entry_time_i, query_time_i;
  logic signed [POS_W-1:0] entry_x_i, entry_y_i;
  logic signed [HDG_W-1:0] entry_heading_i;
  logic out_valid_o, out_ready_i;
  logic signed [POS_W-1:0] pose_x_o, pose_y_o, pose_z_o;
  logic signed [HDG_W-1:0] pose_heading_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  waypoint_pose_interpolator uut (.*);

  item_t   pending_items[$];
  pose_t   pose_q[$];
  bit      failed;
  bit      calm;
  int      n_drv, n_acc, n_out, n_out_seen;
  int      tx_gap, rx_stall, cycles;

  // predictor state
  logic [TIME_W-1:0]       wp_t[N_SLOTS];
  logic signed [POS_W-1:0] wp_x[N_SLOTS];
  logic signed [POS_W-1:0] wp_y[N_SLOTS];
  logic signed [HDG_W-1:0] wp_h[N_SLOTS];
  bit                      loop_on;
  logic signed [POS_W-1:0] height;
  logic [CNT_W-1:0]        wp_count;

  // stimulus copy of the table times
  logic [TIME_W-1:0] plan_t[N_SLOTS];
  int                plan_n;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint lerp_q(longint a, longint b, longint s);
    return a + ((s * (b - a)) >>> FRAC_W);
  endfunction

  function automatic bit predict_pose(input logic [TIME_W-1:0] qt, output pose_t p);
    int n, i;
    logic [TIME_W-1:0] t, t0, t1;
    logic [79:0] q;
    longint s, d;
    n = (wp_count > N_SLOTS) ? N_SLOTS : int'(wp_count);
    p = '{default: '0};
    if (n < 2) return 1'b0;
    t = qt;
    t0 = wp_t[0];
    t1 = wp_t[n-1];
    if (loop_on && t1 > t0 && t > t1) t = t0 + (t - t0) % (t1 - t0);
    p.z = height;
    if (t <= t0) begin
      p.x = wp_x[0]; p.y = wp_y[0]; p.h = wp_h[0];
    end else if (t >= t1) begin
      p.x = wp_x[n-1]; p.y = wp_y[n-1]; p.h = wp_h[n-1];
    end else begin
      i = 1;
      while (i < n - 1 && wp_t[i] < t) i++;
      q = ({32'd0, t - wp_t[i-1]} << FRAC_W) / {32'd0, wp_t[i] - wp_t[i-1]};
      s = longint'(q);
      p.x = POS_W'(lerp_q(wp_x[i-1], wp_x[i], s));
      p.y = POS_W'(lerp_q(wp_y[i-1], wp_y[i], s));
      d = longint'(wp_h[i]) - longint'(wp_h[i-1]);
      if (d > 32768) d -= 65536;
      else if (d < -32768) d += 65536;
      p.h = HDG_W'(longint'(wp_h[i-1]) + ((s * d) >>> FRAC_W));
    end
    return 1'b1;
  endfunction

  // input transfer: update table or predict the pose
  always @(posedge clk_i) begin
    pose_t p;
    if (rst_ni && in_valid_i && in_ready_o) begin
      n_acc <= n_acc + 1;
      if (mode_i == MODE_LOAD) begin
        wp_t[entry_index_i] <= entry_time_i;
        wp_x[entry_index_i] <= entry_x_i;
        wp_y[entry_index_i] <= entry_y_i;
        wp_h[entry_index_i] <= entry_heading_i;
      end else if (!paused_i && predict_pose(query_time_i, p)) begin
        pose_q.insert(pose_q.size(), p);
      end
    end
  end

  // config mirror
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOOP:   loop_on <= cfg_data_i[0];
        CFG_HEIGHT: height <= cfg_data_i;
        CFG_COUNT:  wp_count <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // output transfer check
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out <= n_out + 1;
      if (pose_q.size() == 0) begin
        $display("%0t unexpected pose x=%0d y=%0d z=%0d h=%0d", $time,
                 pose_x_o, pose_y_o, pose_z_o, pose_heading_o);
        failed = 1'b1;
      end else begin
        e = pose_q.pop_front();
        if (e.x !== pose_x_o || e.y !== pose_y_o || e.z !== pose_z_o ||
            e.h !== pose_heading_o) begin
          $display("%0t pose mismatch: expected x=%0d y=%0d z=%0d h=%0d", $time,
                   e.x, e.y, e.z, e.h);
          $display("%0t                actual   x=%0d y=%0d z=%0d h=%0d", $time,
                   pose_x_o, pose_y_o, pose_z_o, pose_heading_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[waypoint_pose_interpolator] ERROR");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && n_drv != n_acc)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        mode_i <= it.mode;
        paused_i <= it.paused;
        entry_index_i <= it.idx;
        entry_time_i <= it.et;
        entry_x_i <= it.ex;
        entry_y_i <= it.ey;
        entry_heading_i <= it.eh;
        query_time_i <= it.qt;
        in_valid_i <= 1'b1;
        n_drv <= n_drv + 1;
        tx_gap <= calm ? 0 : $urandom_range(0, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    int st;
    if (n_out != n_out_seen) begin
      st = calm ? 0 : $urandom_range(0, 16);
      n_out_seen <= n_out;
      rx_stall <= (st > 0) ? st - 1 : 0;
      out_ready_i <= (st == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic push_load(int idx, logic [TIME_W-1:0] t, logic [31:0] x, logic [31:0] y,
                           logic [15:0] h);
    item_t it;
    it.mode = MODE_LOAD;
    it.paused = 1'($urandom_range(0, 1));
    it.idx = IDX_W'(idx);
    it.et = t;
    it.ex = x;
    it.ey = y;
    it.eh = h;
    it.qt = rand_time();
    pending_items.insert(pending_items.size(), it);
    plan_t[idx] = t;
  endtask

  task automatic push_query(bit paused, logic [TIME_W-1:0] t);
    item_t it;
    it.mode = MODE_QUERY;
    it.paused = paused;
    it.idx = IDX_W'($urandom);
    it.et = rand_time();
    it.ex = $urandom;
    it.ey = $urandom;
    it.eh = HDG_W'($urandom);
    it.qt = t;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || n_drv != n_acc || in_valid_i || pose_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(bit lp, logic [31:0] hz, int cnt);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(CFG_LOOP, CFG_W'(lp));
    write_reg(CFG_HEIGHT, hz);
    write_reg(CFG_COUNT, CFG_W'(cnt));
    plan_n = (cnt > N_SLOTS) ? N_SLOTS : cnt;
  endtask

  // kind 0: small steps, 1: large steps, 2: all times equal
  task automatic load_table(int kind);
    logic [TIME_W-1:0] t;
    t = (kind == 1) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 5000));
    for (int i = 0; i < N_SLOTS; i++) begin
      push_load(i, t, $urandom, $urandom, 16'($urandom));
      if (kind == 0) t += $urandom_range(1, 2000);
      else if (kind == 1) t += TIME_W'({$urandom_range(0, 4095), $urandom} + 1);
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int k;
    logic [TIME_W-1:0] t0, t1;
    k = $urandom_range(0, 9);
    t0 = plan_t[0];
    t1 = plan_t[(plan_n < 1) ? 0 : plan_n - 1];
    case (k)
      0: return t0 - $urandom_range(0, 3);
      1: return t1 + $urandom_range(0, 3);
      2: return plan_t[$urandom_range(0, N_SLOTS - 1)];
      3: return rand_time();
      4: return t1 + ((t1 - t0) * $urandom_range(1, 5)) + $urandom_range(0, 100);
      5: return {TIME_W{1'b1}};
      default: return (t1 > t0) ? t0 + rand_time() % (t1 - t0 + 1) : t0;
    endcase
  endfunction

  initial begin
    int kind, cnt;
    logic [31:0] hz;
    failed = 1'b0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    mode_i = MODE_LOAD;
    paused_i = 1'b0;
    entry_index_i = '0;
    entry_time_i = '0;
    entry_x_i = '0;
    entry_y_i = '0;
    entry_heading_i = '0;
    query_time_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_LOOP;
    cfg_data_i = '0;
    n_drv = 0; n_acc = 0; n_out = 0; n_out_seen = 0;
    tx_gap = 0; rx_stall = 0; cycles = 0;
    loop_on = 1'b0;
    height = HEIGHT_RESET;
    wp_count = '0;
    plan_n = 0;
    foreach (wp_t[i]) begin
      wp_t[i] = '0; wp_x[i] = '0; wp_y[i] = '0; wp_h[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, half-turn steps, max time
    load_table(0);
    push_load(0, 0, 32'h8000_0000, 32'h7fff_ffff, 16'h8000);
    push_load(1, 1000, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff);
    push_load(2, 1500, 0, 0, 16'hc000);
    push_load(3, 2000, 1, -1, 16'h4000);
    push_load(4, 2500, -1, 1, 16'hc000);
    push_load(15, {TIME_W{1'b1}}, 5, 7, 16'h0001);
    push_query(1'b0, 500);
    push_query(1'b0, 1750);
    set_regs(1'b0, HEIGHT_RESET, 1);
    push_query(1'b0, 500);
    set_regs(1'b0, 32'h8000_0000, 2);
    push_query(1'b0, 0);
    push_query(1'b0, 1);
    push_query(1'b0, 999);
    push_query(1'b1, 500);
    push_query(1'b0, {TIME_W{1'b1}});
    set_regs(1'b0, 32'h7fff_ffff, 16);
    push_query(1'b0, 1750);
    push_query(1'b0, 2250);
    push_query(1'b0, {TIME_W{1'b1}} - 1);
    push_query(1'b0, {TIME_W{1'b1}});
    set_regs(1'b1, 32'h0, 31);
    push_query(1'b0, {TIME_W{1'b1}});
    push_query(1'b0, 1234);
    set_regs(1'b1, 32'h1234_5678, 5);
    push_query(1'b0, 7777);
    push_query(1'b0, 2500);

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      kind = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1);
      load_table(kind);
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      hz = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 32'h7fff_ffff
                                                                       : 32'h8000_0000)
                                       : $urandom;
      calm = (ph % 5 == 4);
      set_regs(1'($urandom_range(0, 1)), hz, cnt);
      for (int k = 0; k < 110; k++) begin
        if ($urandom_range(0, 19) == 0)
          push_load($urandom_range(0, N_SLOTS - 1), rand_time(), $urandom, $urandom,
                    16'($urandom));
        else
          push_query($urandom_range(0, 9) == 0, pick_time());
        if (k == 60 && ph % 3 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (!failed) begin
      $display("[waypoint_pose_interpolator] OK");
    end else begin
      $display("[waypoint_pose_interpolator] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/wpi_pkg.sv
sv/wpi_dp.sv
sv/wpi_ctrl.sv
sv/waypoint_pose_interpolator.sv
test/tb_waypoint_pose_interpolator.sv
